### rtl/cpat_pkg.sv
// Shared constants and tables for the circle point evaluator.
package cpat_pkg;

    // Build-time configuration.
    localparam int CORDIC_STAGES = 18;
    localparam int PHASE_BITS    = 32;

    // Interface widths.
    localparam int COORD_W    = 48;
    localparam int RATE_W     = 48;
    localparam int OFFSET_W   = 32;
    localparam int TIME_W     = 40;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 48;

    // The product of rate and time is in units of 2^-48 turn.
    localparam int ALIGN_W  = 48;
    localparam int TLO_W    = TIME_W / 2;
    localparam int THI_W    = TIME_W - TLO_W;
    localparam int HI_KEEP  = ALIGN_W - TLO_W;
    localparam int PWORD_LSB = ALIGN_W - PHASE_BITS;
    localparam int SH_UP    = (PHASE_BITS >= OFFSET_W) ? PHASE_BITS - OFFSET_W : 0;
    localparam int SH_DN    = (PHASE_BITS < OFFSET_W) ? OFFSET_W - PHASE_BITS : 0;

    // CORDIC datapath.
    localparam int ANGLE_W   = 32;
    localparam int Z_W       = ANGLE_W + 1;
    localparam int XY_W      = 20;
    localparam int TRIG_W    = 19;
    localparam int FRAC_BITS = 17;
    localparam int GAIN_INIT = 79594;
    localparam int ONE_Q17   = 131072;

    // Combine datapath.
    localparam int PROD_W = COORD_W + TRIG_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int RND_W  = SUM_W - FRAC_BITS;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_U_X       = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_U_Y       = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_U_Z       = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_V_X       = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_V_Y       = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_V_Z       = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ANGULAR_RATE   = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_OFFSET   = 4'd7;

    // Arctangent of 2^-i in units of 2^-32 turn.
    function automatic logic signed [Z_W-1:0] atan_angle(input int i);
        logic signed [Z_W-1:0] a;
        unique case (i)
            0:  a = Z_W'(536870912);
            1:  a = Z_W'(316933406);
            2:  a = Z_W'(167458907);
            3:  a = Z_W'(85004756);
            4:  a = Z_W'(42667331);
            5:  a = Z_W'(21354465);
            6:  a = Z_W'(10679838);
            7:  a = Z_W'(5340245);
            8:  a = Z_W'(2670163);
            9:  a = Z_W'(1335087);
            10: a = Z_W'(667544);
            11: a = Z_W'(333772);
            12: a = Z_W'(166886);
            13: a = Z_W'(83443);
            14: a = Z_W'(41722);
            15: a = Z_W'(20861);
            16: a = Z_W'(10430);
            17: a = Z_W'(5215);
            18: a = Z_W'(2608);
            19: a = Z_W'(1304);
            20: a = Z_W'(652);
            21: a = Z_W'(326);
            22: a = Z_W'(163);
            23: a = Z_W'(81);
            24: a = Z_W'(41);
            25: a = Z_W'(20);
            26: a = Z_W'(10);
            27: a = Z_W'(5);
            28: a = Z_W'(3);
            29: a = Z_W'(1);
            30: a = Z_W'(1);
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

### rtl/circle_point_at_time_top.sv
// Pipeline from an accepted time word to the result word: the two-part phase multiply,
// phase add, fold, one CORDIC micro-rotation per stage, clamp, axis multiply, rounding
// add and the output register. Throughput: one word per cycle while the result side
// takes words; an output skid stage keeps input flowing when the result side stalls,
// until a word parks in it. Reset (aresetn low at a clock edge) empties the pipeline
// and clears all configuration registers to zero.
module circle_point_at_time_top (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    cfg_we,
    input  logic [cpat_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [cpat_pkg::CFG_DATA_W-1:0]         cfg_data,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic [cpat_pkg::TIME_W-1:0]             s_time_value,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic signed [cpat_pkg::COORD_W-1:0]     m_pos_x,
    output logic signed [cpat_pkg::COORD_W-1:0]     m_pos_y,
    output logic signed [cpat_pkg::COORD_W-1:0]     m_pos_z
);

    localparam int N         = cpat_pkg::CORDIC_STAGES;
    localparam int NPIPE     = N + 6;
    localparam int FOLD_IDX  = 2;
    localparam int CLAMP_IDX = N + 3;

    localparam logic signed [cpat_pkg::Z_W-1:0] QUARTER = cpat_pkg::Z_W'(64'sd1073741824);
    localparam logic signed [cpat_pkg::Z_W-1:0] HALF    = cpat_pkg::Z_W'(64'sd2147483648);
    localparam logic signed [cpat_pkg::XY_W-1:0] ONE_XY =
        cpat_pkg::XY_W'(cpat_pkg::ONE_Q17);
    localparam logic signed [cpat_pkg::TRIG_W-1:0] ONE_T =
        cpat_pkg::TRIG_W'(cpat_pkg::ONE_Q17);
    localparam logic signed [cpat_pkg::SUM_W-1:0] ROUND_HALF =
        cpat_pkg::SUM_W'(1) << (cpat_pkg::FRAC_BITS - 1);

    // Configuration registers.
    logic signed [cpat_pkg::COORD_W-1:0]  axis_u_reg [0:2];
    logic signed [cpat_pkg::COORD_W-1:0]  axis_v_reg [0:2];
    logic signed [cpat_pkg::RATE_W-1:0]   rate_reg;
    logic [cpat_pkg::OFFSET_W-1:0]        offset_reg;

    // Pipeline control.
    logic [NPIPE-1:0] vld_reg;
    logic             en;
    logic             m_valid_reg;
    logic             skid_v_reg;

    // Phase datapath.
    logic [cpat_pkg::RATE_W+cpat_pkg::TLO_W-1:0]   mul_lo;
    logic [cpat_pkg::HI_KEEP+cpat_pkg::THI_W-1:0]  mul_hi;
    logic [cpat_pkg::ALIGN_W-1:0]                  p_lo_reg;
    logic [cpat_pkg::HI_KEEP-1:0]                  p_hi_reg;
    logic [cpat_pkg::ALIGN_W-1:0]                  prod_sum;
    logic [cpat_pkg::ALIGN_W-1:0]                  off_ext;
    logic [cpat_pkg::ALIGN_W-1:0]                  off_shift;
    logic [cpat_pkg::PHASE_BITS-1:0]               phase;
    logic [cpat_pkg::ALIGN_W-1:0]                  ph_shift;
    logic [cpat_pkg::ANGLE_W-1:0]                  a32_reg;

    // Fold and CORDIC stages.
    logic signed [cpat_pkg::Z_W-1:0]  z_raw;
    logic signed [cpat_pkg::Z_W-1:0]  z_fold;
    logic                             neg_fold;
    logic signed [cpat_pkg::XY_W-1:0] cx_reg [0:N];
    logic signed [cpat_pkg::XY_W-1:0] cy_reg [0:N];
    logic signed [cpat_pkg::Z_W-1:0]  cz_reg [0:N];
    logic                             cn_reg [0:N];
    logic signed [cpat_pkg::XY_W-1:0] cx_next [1:N];
    logic signed [cpat_pkg::XY_W-1:0] cy_next [1:N];
    logic signed [cpat_pkg::Z_W-1:0]  cz_next [1:N];

    // Clamp and combine.
    logic signed [cpat_pkg::XY_W-1:0]   xs, ys;
    logic signed [cpat_pkg::TRIG_W-1:0] cos_next, sin_next;
    logic signed [cpat_pkg::TRIG_W-1:0] cos_reg, sin_reg;
    logic signed [cpat_pkg::PROD_W-1:0] pu_reg [0:2];
    logic signed [cpat_pkg::PROD_W-1:0] pv_reg [0:2];
    logic signed [cpat_pkg::SUM_W-1:0]  sum_w [0:2];
    logic signed [cpat_pkg::RND_W-1:0]  rnd_reg [0:2];
    logic signed [cpat_pkg::COORD_W-1:0] sat_w [0:2];
    logic signed [cpat_pkg::COORD_W-1:0] out_reg [0:2];
    logic signed [cpat_pkg::COORD_W-1:0] skid_reg [0:2];

    // The whole pipeline moves unless a word is parked in the skid stage.
    assign en      = !skid_v_reg;
    assign s_ready = en;

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                axis_u_reg[i] <= '0;
                axis_v_reg[i] <= '0;
            end
            rate_reg   <= '0;
            offset_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                cpat_pkg::REG_AXIS_U_X:     axis_u_reg[0] <= cfg_data;
                cpat_pkg::REG_AXIS_U_Y:     axis_u_reg[1] <= cfg_data;
                cpat_pkg::REG_AXIS_U_Z:     axis_u_reg[2] <= cfg_data;
                cpat_pkg::REG_AXIS_V_X:     axis_v_reg[0] <= cfg_data;
                cpat_pkg::REG_AXIS_V_Y:     axis_v_reg[1] <= cfg_data;
                cpat_pkg::REG_AXIS_V_Z:     axis_v_reg[2] <= cfg_data;
                cpat_pkg::REG_ANGULAR_RATE: rate_reg      <= cfg_data;
                cpat_pkg::REG_PHASE_OFFSET: offset_reg    <= cfg_data[cpat_pkg::OFFSET_W-1:0];
                default: ;
            endcase
        end
    end

    // Rate times time, modulo 2^48, split over the two halves of the time word.
    assign mul_lo = $unsigned(rate_reg) * s_time_value[cpat_pkg::TLO_W-1:0];
    assign mul_hi = rate_reg[cpat_pkg::HI_KEEP-1:0] *
                    s_time_value[cpat_pkg::TIME_W-1:cpat_pkg::TLO_W];

    // Phase word: product bits plus the aligned offset, then aligned to 32 bits.
    always_comb begin
        prod_sum  = p_lo_reg + {p_hi_reg, {cpat_pkg::TLO_W{1'b0}}};
        off_ext   = cpat_pkg::ALIGN_W'(offset_reg);
        off_shift = (off_ext << cpat_pkg::SH_UP) >> cpat_pkg::SH_DN;
        phase     = prod_sum[cpat_pkg::ALIGN_W-1:cpat_pkg::PWORD_LSB] +
                    off_shift[cpat_pkg::PHASE_BITS-1:0];
        ph_shift  = (cpat_pkg::ALIGN_W'(phase) >> cpat_pkg::SH_UP) << cpat_pkg::SH_DN;
    end

    // Fold the angle into a quarter turn either side of zero.
    always_comb begin
        z_raw    = $signed({a32_reg[cpat_pkg::ANGLE_W-1], a32_reg});
        z_fold   = z_raw;
        neg_fold = 1'b0;
        priority if (z_raw > QUARTER) begin
            z_fold   = z_raw - HALF;
            neg_fold = 1'b1;
        end else if (z_raw < -QUARTER) begin
            z_fold   = z_raw + HALF;
            neg_fold = 1'b1;
        end
    end

    // One micro-rotation per stage.
    always_comb begin
        for (int k = 0; k < N; k++) begin
            if (!cz_reg[k][cpat_pkg::Z_W-1]) begin
                cx_next[k+1] = cx_reg[k] - (cy_reg[k] >>> k);
                cy_next[k+1] = cy_reg[k] + (cx_reg[k] >>> k);
                cz_next[k+1] = cz_reg[k] - cpat_pkg::atan_angle(k);
            end else begin
                cx_next[k+1] = cx_reg[k] + (cy_reg[k] >>> k);
                cy_next[k+1] = cy_reg[k] - (cx_reg[k] >>> k);
                cz_next[k+1] = cz_reg[k] + cpat_pkg::atan_angle(k);
            end
        end
    end

    // Undo the half-turn fold and clamp cos and sin to one.
    always_comb begin
        xs = cn_reg[N] ? -cx_reg[N] : cx_reg[N];
        ys = cn_reg[N] ? -cy_reg[N] : cy_reg[N];
        priority if (xs > ONE_XY)       cos_next = ONE_T;
        else if (xs < -ONE_XY)          cos_next = -ONE_T;
        else                            cos_next = xs[cpat_pkg::TRIG_W-1:0];
        priority if (ys > ONE_XY)       sin_next = ONE_T;
        else if (ys < -ONE_XY)          sin_next = -ONE_T;
        else                            sin_next = ys[cpat_pkg::TRIG_W-1:0];
    end

    // Round half up, then saturate to the coordinate range.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sum_w[i] = cpat_pkg::SUM_W'(pu_reg[i]) + cpat_pkg::SUM_W'(pv_reg[i]) + ROUND_HALF;
            if (rnd_reg[i][cpat_pkg::RND_W-1:cpat_pkg::COORD_W-1] == '0 ||
                rnd_reg[i][cpat_pkg::RND_W-1:cpat_pkg::COORD_W-1] == '1) begin
                sat_w[i] = rnd_reg[i][cpat_pkg::COORD_W-1:0];
            end else if (rnd_reg[i][cpat_pkg::RND_W-1]) begin
                sat_w[i] = {1'b1, {(cpat_pkg::COORD_W-1){1'b0}}};
            end else begin
                sat_w[i] = {1'b0, {(cpat_pkg::COORD_W-1){1'b1}}};
            end
        end
    end

    // Pipeline data registers; they advance together with the valid bits.
    always_ff @(posedge aclk) begin
        if (en) begin
            p_lo_reg  <= mul_lo[cpat_pkg::ALIGN_W-1:0];
            p_hi_reg  <= mul_hi[cpat_pkg::HI_KEEP-1:0];
            a32_reg   <= ph_shift[cpat_pkg::ANGLE_W-1:0];
            cx_reg[0] <= cpat_pkg::XY_W'(cpat_pkg::GAIN_INIT);
            cy_reg[0] <= '0;
            cz_reg[0] <= z_fold;
            cn_reg[0] <= neg_fold;
            for (int k = 1; k <= N; k++) begin
                cx_reg[k] <= cx_next[k];
                cy_reg[k] <= cy_next[k];
                cz_reg[k] <= cz_next[k];
                cn_reg[k] <= cn_reg[k-1];
            end
            cos_reg <= cos_next;
            sin_reg <= sin_next;
            for (int i = 0; i < 3; i++) begin
                pu_reg[i]  <= axis_u_reg[i] * cos_reg;
                pv_reg[i]  <= axis_v_reg[i] * sin_reg;
                rnd_reg[i] <= sum_w[i][cpat_pkg::SUM_W-1:cpat_pkg::FRAC_BITS];
            end
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NPIPE-2:0], s_valid};
        end
    end

    // Output register with a skid stage behind it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            skid_v_reg  <= 1'b0;
        end else if (!m_valid_reg || m_ready) begin
            m_valid_reg <= skid_v_reg || (en && vld_reg[NPIPE-1]);
            skid_v_reg  <= 1'b0;
        end else if (en && vld_reg[NPIPE-1]) begin
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!m_valid_reg || m_ready) begin
            for (int i = 0; i < 3; i++) begin
                out_reg[i] <= skid_v_reg ? skid_reg[i] : sat_w[i];
            end
        end else if (en && vld_reg[NPIPE-1]) begin
            for (int i = 0; i < 3; i++) begin
                skid_reg[i] <= sat_w[i];
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_pos_x = out_reg[0];
    assign m_pos_y = out_reg[1];
    assign m_pos_z = out_reg[2];

    // A word only parks in the skid stage behind a held output word.
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_v_reg |-> m_valid_reg)
        else $error("skid stage holds a word while the output is empty");

    a_skid_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_v_reg) |-> $past(m_valid_reg && !m_ready && vld_reg[NPIPE-1]))
        else $error("skid stage filled without a stalled output");

    a_fold_range: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[FOLD_IDX] |-> (cz_reg[0] <= QUARTER && cz_reg[0] >= -QUARTER))
        else $error("folded angle outside a quarter turn");

    a_trig_range: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[CLAMP_IDX] |-> (cos_reg <= ONE_T && cos_reg >= -ONE_T &&
                                sin_reg <= ONE_T && sin_reg >= -ONE_T))
        else $error("cos or sin beyond unit range");

endmodule
